/* hdl/drbl_pkg.sv */
`default_nettype none

package drbl_pkg;

  // default sizing
  localparam int unsigned BankCountDef = 16;
  localparam int unsigned AddrBitsDef  = 48;

  // field widths
  localparam int unsigned LINE_ADDR_W = 48;
  localparam int unsigned LAT_W       = 12;
  localparam int unsigned TIM_W       = 10;
  localparam int unsigned SHIFT_W     = 4;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 12;
  localparam int unsigned CNT_W       = 48;
  localparam int unsigned SUM_W       = 64;

  // configuration reset values
  localparam logic               RST_ROW_BUFFER_MODE = 1'b1;
  localparam logic [SHIFT_W-1:0] RST_LINES_PER_ROW   = 4'd4;
  localparam logic [LAT_W-1:0]   RST_FIXED_LATENCY   = 12'd100;
  localparam logic [TIM_W-1:0]   RST_T_ACT           = 10'd45;
  localparam logic [TIM_W-1:0]   RST_T_CAS           = 10'd45;
  localparam logic [TIM_W-1:0]   RST_T_PRE           = 10'd45;
  localparam logic [TIM_W-1:0]   RST_T_BUS           = 10'd10;

  typedef enum logic [2:0] {
    OUT_READ_HIT      = 3'd0,
    OUT_READ_CLOSED   = 3'd1,
    OUT_READ_CONFLICT = 3'd2,
    OUT_WRITE         = 3'd3,
    OUT_FIXED         = 3'd4
  } row_outcome_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_BUFFER_MODE = 3'd0,
    CFG_LINES_PER_ROW   = 3'd1,
    CFG_FIXED_LATENCY   = 3'd2,
    CFG_T_ACT           = 3'd3,
    CFG_T_CAS           = 3'd4,
    CFG_T_PRE           = 3'd5,
    CFG_T_BUS           = 3'd6
  } cfg_idx_e;

endpackage

`default_nettype wire

/* hdl/drbl_bank_map.sv */
`default_nettype none

// Row index and bank select: idx = addr >> shift, bank = idx mod BANK_COUNT.
// Stage 1 sums per-bit residues of 2^i, stage 2 divides that small sum by
// reciprocal multiply, the remainder is formed at the output.
module drbl_bank_map import drbl_pkg::*; #(
  parameter  int unsigned BANK_COUNT = BankCountDef,
  parameter  int unsigned ADDR_BITS  = AddrBitsDef,
  localparam int unsigned AW = (ADDR_BITS < LINE_ADDR_W) ? ADDR_BITS : LINE_ADDR_W,
  localparam int unsigned BW = $clog2(BANK_COUNT)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   in_valid_i,
  input  wire logic [LINE_ADDR_W-1:0] line_addr_i,
  input  wire logic                   is_write_i,
  input  wire logic [SHIFT_W-1:0]     shift_i,
  output logic                        out_valid_o,
  output logic                        out_write_o,
  output logic [AW-1:0]               out_idx_o,
  output logic [BW-1:0]               out_bank_o
);

  localparam int unsigned SW      = $clog2(AW * (BANK_COUNT - 1) + 1);
  localparam int unsigned SH      = SW + BW;
  localparam int unsigned RECIP_W = SH + 1;
  localparam int unsigned PW      = SW + RECIP_W;
  localparam int unsigned Recip   = ((2 ** SH) + BANK_COUNT - 1) / BANK_COUNT;

  function automatic int unsigned pow2_mod(input int unsigned k);
    int unsigned c;
    c = 1;
    for (int unsigned j = 0; j < k; j++) begin
      c = c * 2;
      if (c >= BANK_COUNT) begin
        c = c - BANK_COUNT;
      end
    end
    return c;
  endfunction

  logic          v0_q, v1_q, v2_q;
  logic [AW-1:0] addr0_q;
  logic          wr0_q, wr1_q, wr2_q;
  logic [AW-1:0] idx1_d, idx1_q, idx2_q;
  logic [SW-1:0] sum1_d, sum1_q, sum2_q;
  logic [PW-1:0] prod;
  logic [SW-1:0] quo2_d, quo2_q;
  logic [SW-1:0] qn;
  logic [SW-1:0] rem;
  logic [BW-1:0] term [AW];

  assign idx1_d = addr0_q >> shift_i;

  for (genvar g = 0; g < AW; g++) begin : g_term
    localparam int unsigned Wv = pow2_mod(g);
    assign term[g] = idx1_d[g] ? BW'(Wv) : '0;
  end

  always_comb begin
    sum1_d = '0;
    for (int unsigned i = 0; i < AW; i++) begin
      sum1_d = sum1_d + SW'(term[i]);
    end
  end

  assign prod   = PW'(sum1_q) * PW'(Recip);
  assign quo2_d = prod[SH +: SW];

  assign qn  = SW'(quo2_q * SW'(BANK_COUNT));
  assign rem = sum2_q - qn;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      addr0_q <= line_addr_i[AW-1:0];
      wr0_q   <= is_write_i;
      idx1_q  <= idx1_d;
      sum1_q  <= sum1_d;
      wr1_q   <= wr0_q;
      idx2_q  <= idx1_q;
      sum2_q  <= sum1_q;
      quo2_q  <= quo2_d;
      wr2_q   <= wr1_q;
    end
  end

  assign out_valid_o = v2_q;
  assign out_write_o = wr2_q;
  assign out_idx_o   = idx2_q;
  assign out_bank_o  = rem[BW-1:0];

endmodule

`default_nettype wire

/* hdl/dram_row_buffer_latency_core.sv */
`default_nettype none

// DRAM open-page latency model.
// Input channel: in_valid_i / in_stall_o carry one access request (line_addr_i,
// is_write_i). Output channel: out_valid_o / out_stall_i carry the latency, the
// row outcome and the running read/write counts and latency totals.
// Pipeline: a result passes the input register, residue sum, reciprocal
// divide, table read and result register after its request is accepted.
// Throughput: one request per cycle, sustained while out_stall_i is low.
// The bank select needs idx mod BANK_COUNT; that is a two-stage residue pipe,
// the open-row table is read with a registered port and updated in the last
// stage, with a one-entry bypass for a back-to-back access to the same bank.
// Stall: the whole pipe freezes while a result waits on out_stall_i, and
// in_stall_o is raised in the same cycle, so nothing is dropped.
// Reset: config returns to its default values, the open-row flags and all
// counters clear; the row-id memory needs no clearing (it is only compared
// while its flag is set). The user writes config through cfg_wen_i /
// cfg_idx_i / cfg_wdata_i only while no request is in flight; not enforced.
module dram_row_buffer_latency_core import drbl_pkg::*; #(
  parameter int unsigned BANK_COUNT = BankCountDef,
  parameter int unsigned ADDR_BITS  = AddrBitsDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_wen_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [LINE_ADDR_W-1:0] line_addr_i,
  input  wire logic                   is_write_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [LAT_W-1:0]            latency_o,
  output logic [2:0]                  row_outcome_o,
  output logic [CNT_W-1:0]            read_count_o,
  output logic [CNT_W-1:0]            write_count_o,
  output logic [SUM_W-1:0]            read_latency_total_o,
  output logic [SUM_W-1:0]            write_latency_total_o
);

  localparam int unsigned AW = (ADDR_BITS < LINE_ADDR_W) ? ADDR_BITS : LINE_ADDR_W;
  localparam int unsigned BW = $clog2(BANK_COUNT);

  // configuration
  logic               row_buffer_mode_q;
  logic [SHIFT_W-1:0] lines_per_row_q;
  logic [LAT_W-1:0]   fixed_latency_q;
  logic [TIM_W-1:0]   t_act_q, t_cas_q, t_pre_q, t_bus_q;

  // pipe control: everything moves when the result register can load
  logic adv;

  // bank map outputs
  logic          map_valid, map_write;
  logic [AW-1:0] map_idx;
  logic [BW-1:0] map_bank;

  // table read stage
  logic          v3_q, wr3_q;
  logic [AW-1:0] idx3_q, rdata3_q;
  logic [BW-1:0] bank3_q;

  // open-row table: flags in flops, row ids in memory
  logic [BANK_COUNT-1:0] open_q;
  logic [AW-1:0]         mem_q [BANK_COUNT];

  // same-edge write bypass
  logic          byp_v_q;
  logic [BW-1:0] byp_bank_q;
  logic [AW-1:0] byp_idx_q;

  // decision
  logic [LAT_W-1:0] t_bc, t_bca, t_all;
  logic [AW-1:0]    stored_idx;
  logic             bank_open, row_hit;
  logic [LAT_W-1:0] lat_d;
  row_outcome_e     outcome_d;
  logic             tbl_wr, set_open, fire;

  // results
  logic             out_valid_q;
  logic [LAT_W-1:0] latency_q;
  row_outcome_e     outcome_q;
  logic [CNT_W-1:0] read_cnt_q, write_cnt_q;
  logic [SUM_W-1:0] read_sum_q, write_sum_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_buffer_mode_q <= RST_ROW_BUFFER_MODE;
      lines_per_row_q   <= RST_LINES_PER_ROW;
      fixed_latency_q   <= RST_FIXED_LATENCY;
      t_act_q           <= RST_T_ACT;
      t_cas_q           <= RST_T_CAS;
      t_pre_q           <= RST_T_PRE;
      t_bus_q           <= RST_T_BUS;
    end else if (cfg_wen_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ROW_BUFFER_MODE: row_buffer_mode_q <= cfg_wdata_i[0];
        CFG_LINES_PER_ROW:   lines_per_row_q   <= cfg_wdata_i[SHIFT_W-1:0];
        CFG_FIXED_LATENCY:   fixed_latency_q   <= cfg_wdata_i[LAT_W-1:0];
        CFG_T_ACT:           t_act_q           <= cfg_wdata_i[TIM_W-1:0];
        CFG_T_CAS:           t_cas_q           <= cfg_wdata_i[TIM_W-1:0];
        CFG_T_PRE:           t_pre_q           <= cfg_wdata_i[TIM_W-1:0];
        CFG_T_BUS:           t_bus_q           <= cfg_wdata_i[TIM_W-1:0];
        default: ;
      endcase
    end
  end

  drbl_bank_map #(
    .BANK_COUNT (BANK_COUNT),
    .ADDR_BITS  (ADDR_BITS)
  ) u_bank_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .in_valid_i  (in_valid_i),
    .line_addr_i (line_addr_i),
    .is_write_i  (is_write_i),
    .shift_i     (lines_per_row_q),
    .out_valid_o (map_valid),
    .out_write_o (map_write),
    .out_idx_o   (map_idx),
    .out_bank_o  (map_bank)
  );

  // table read stage; memory read data registered with the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= map_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wr3_q    <= map_write;
      idx3_q   <= map_idx;
      bank3_q  <= map_bank;
      rdata3_q <= mem_q[map_bank];
    end
    if (fire && tbl_wr) begin
      mem_q[bank3_q] <= idx3_q;
    end
  end

  // timing sums, at most 4 * 1023
  assign t_bc  = LAT_W'(t_bus_q) + LAT_W'(t_cas_q);
  assign t_bca = t_bc + LAT_W'(t_act_q);
  assign t_all = t_bca + LAT_W'(t_pre_q);

  // same bank implies same low residue, so comparing the full row index is
  // equivalent to comparing the row number
  assign stored_idx = (byp_v_q && (byp_bank_q == bank3_q)) ? byp_idx_q : rdata3_q;
  assign bank_open  = open_q[bank3_q];
  assign row_hit    = bank_open && (stored_idx == idx3_q);
  assign fire       = adv && v3_q;

  always_comb begin
    lat_d     = fixed_latency_q;
    outcome_d = OUT_FIXED;
    tbl_wr    = 1'b0;
    set_open  = 1'b0;
    if (row_buffer_mode_q) begin
      if (wr3_q) begin
        // writes record the row but leave the open flag alone
        lat_d     = t_all;
        outcome_d = OUT_WRITE;
        tbl_wr    = 1'b1;
      end else if (row_hit) begin
        lat_d     = t_bc;
        outcome_d = OUT_READ_HIT;
      end else if (bank_open) begin
        lat_d     = t_all;
        outcome_d = OUT_READ_CONFLICT;
        tbl_wr    = 1'b1;
      end else begin
        lat_d     = t_bca;
        outcome_d = OUT_READ_CLOSED;
        tbl_wr    = 1'b1;
        set_open  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= '0;
      byp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
      read_cnt_q  <= '0;
      write_cnt_q <= '0;
      read_sum_q  <= '0;
      write_sum_q <= '0;
    end else if (adv) begin
      byp_v_q     <= v3_q && tbl_wr;
      out_valid_q <= v3_q;
      if (v3_q) begin
        if (set_open) begin
          open_q[bank3_q] <= 1'b1;
        end
        if (wr3_q) begin
          write_cnt_q <= write_cnt_q + CNT_W'(1);
          write_sum_q <= write_sum_q + SUM_W'(lat_d);
        end else begin
          read_cnt_q <= read_cnt_q + CNT_W'(1);
          read_sum_q <= read_sum_q + SUM_W'(lat_d);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      byp_bank_q <= bank3_q;
      byp_idx_q  <= idx3_q;
      latency_q  <= lat_d;
      outcome_q  <= outcome_d;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign latency_o             = latency_q;
  assign row_outcome_o         = outcome_q;
  assign read_count_o          = read_cnt_q;
  assign write_count_o         = write_cnt_q;
  assign read_latency_total_o  = read_sum_q;
  assign write_latency_total_o = write_sum_q;

  // open flags are only ever set
  a_open_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> $countones(open_q) >= $past($countones(open_q)))
    else $error("open-row flag cleared");

  // a write bumps the write count by exactly one
  a_write_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && wr3_q) |=> write_cnt_q == $past(write_cnt_q) + CNT_W'(1))
    else $error("write count step wrong");

  // a read hit leaves the table untouched and the bypass invalid
  a_hit_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (outcome_d == OUT_READ_HIT)) |=> !byp_v_q)
    else $error("read hit updated the row table");

endmodule

`default_nettype wire

/* bench/tb_dram_row_buffer_latency_core.sv */
`default_nettype none

// Bench for the DRAM open-page latency core.
// Every bank is primed with a write, then a directed script runs, then ten phases of
// random requests, each phase under its own register setting. Every accepted
// request runs through a local copy of the bank table and the counters. The result
// that copy predicts is queued and matched, in order, against what the core hands out.
module tb_dram_row_buffer_latency_core;
  import drbl_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 8;        // extra slack after the last result
  localparam int unsigned NUM_PHASES   = 10;
  localparam int unsigned PHASE_REQS   = 50;
  localparam int unsigned RECENT_DEPTH = 8;
  localparam int unsigned BANK_SHIFT   = $clog2(BankCountDef);
  localparam logic [63:0] ADDR_MASK    = {64{1'b1}} >> (64 - AddrBitsDef);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;  // no register behind it
  localparam int unsigned RUN_LIMIT    = 2_000_000;

  typedef enum logic {
    STEP_REQ,
    STEP_REG
  } step_kind_e;

  // one line of the directed script: a request or a register write
  typedef struct packed {
    step_kind_e             kind;
    logic [LINE_ADDR_W-1:0] addr;
    logic                   wr;
    logic                   known;     // lat/outcome below are typed in
    logic [LAT_W-1:0]       lat;
    row_outcome_e           outcome;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_data;
  } script_step_t;

  typedef struct {
    logic [LAT_W-1:0] lat;
    row_outcome_e     outcome;
    logic [CNT_W-1:0] reads;
    logic [CNT_W-1:0] writes;
    logic [SUM_W-1:0] rd_sum;
    logic [SUM_W-1:0] wr_sum;
  } access_result_t;

  // Before the script every bank gets a row id from a write, which leaves the
  // bank closed. Timings start at reset values: act/cas/pre 45, bus 10.
  localparam int unsigned SCRIPT_LEN = 34;
  localparam script_step_t SCRIPT [SCRIPT_LEN] = '{
    // closed bank, same-row hit, conflict, hit on the new row
    '{STEP_REQ, 48'h0000_0000_0000, 1'b0, 1'b1, 12'd100, OUT_READ_CLOSED, CFG_T_ACT, 12'd0},
    '{STEP_REQ, 48'h0000_0000_000F, 1'b0, 1'b1, 12'd55, OUT_READ_HIT, CFG_T_ACT, 12'd0},
    '{STEP_REQ, 48'h0000_0000_0100, 1'b0, 1'b1, 12'd145, OUT_READ_CONFLICT, CFG_T_ACT, 12'd0},
    '{STEP_REQ, 48'h0000_0000_010F, 1'b0, 1'b1, 12'd55, OUT_READ_HIT, CFG_T_ACT, 12'd0},
    // a write swaps the row id under an open bank, so the next read conflicts
    '{STEP_REQ, 48'h0000_0000_0000, 1'b1, 1'b1, 12'd145, OUT_WRITE, CFG_T_ACT, 12'd0},
    '{STEP_REQ, 48'h0000_0000_0100, 1'b0, 1'b1, 12'd145, OUT_READ_CONFLICT, CFG_T_ACT, 12'd0},
    // top of the address range
    '{STEP_REQ, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b1, 12'd100, OUT_READ_CLOSED, CFG_T_ACT, 12'd0},
    '{STEP_REQ, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b1, 12'd55, OUT_READ_HIT, CFG_T_ACT, 12'd0},
    '{STEP_REQ, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 12'd145, OUT_WRITE, CFG_T_ACT, 12'd0},
    '{STEP_REQ, 48'h8000_0000_0000, 1'b0, 1'b1, 12'd145, OUT_READ_CONFLICT, CFG_T_ACT, 12'd0},
    // all timings at max: 4 * 1023 still fits in 12 bits
    '{STEP_REG, 48'h0, 1'b0, 1'b0, 12'd0, OUT_READ_HIT, CFG_T_ACT, 12'd1023},
    '{STEP_REG, 48'h0, 1'b0, 1'b0, 12'd0, OUT_READ_HIT, CFG_T_CAS, 12'd1023},
    '{STEP_REG, 48'h0, 1'b0, 1'b0, 12'd0, OUT_READ_HIT, CFG_T_PRE, 12'd1023},
    '{STEP_REG, 48'h0, 1'b0, 1'b0, 12'd0, OUT_READ_HIT, CFG_T_BUS, 12'd1023},
    '{STEP_REQ, 48'h0000_0000_0020, 1'b1, 1'b1, 12'd4092, OUT_WRITE, CFG_T_ACT, 12'd0},
    '{STEP_REQ, 48'h0000_0000_0020, 1'b0, 1'b1, 12'd3069, OUT_READ_CLOSED, CFG_T_ACT, 12'd0},
    // fixed mode; junk above bit 0 of the mode write must be dropped
    '{STEP_REG, 48'h0, 1'b0, 1'b0, 12'd0, OUT_READ_HIT, CFG_ROW_BUFFER_MODE, 12'hFFE},
    '{STEP_REG, 48'h0, 1'b0, 1'b0, 12'd0, OUT_READ_HIT, CFG_FIXED_LATENCY, 12'hFFF},
    '{STEP_REQ, 48'h0000_0000_0020, 1'b0, 1'b1, 12'd4095, OUT_FIXED, CFG_T_ACT, 12'd0},
    '{STEP_REQ, 48'h5A5A_A5A5_5A5A, 1'b1, 1'b1, 12'd4095, OUT_FIXED, CFG_T_ACT, 12'd0},
    '{STEP_REG, 48'h0, 1'b0, 1'b0, 12'd0, OUT_READ_HIT, CFG_FIXED_LATENCY, 12'd0},
    '{STEP_REQ, 48'h0000_0000_0020, 1'b0, 1'b1, 12'd0, OUT_FIXED, CFG_T_ACT, 12'd0},
    // back to row-buffer mode with zero timings and the widest shift
    '{STEP_REG, 48'h0, 1'b0, 1'b0, 12'd0, OUT_READ_HIT, CFG_ROW_BUFFER_MODE, 12'h001},
    '{STEP_REG, 48'h0, 1'b0, 1'b0, 12'd0, OUT_READ_HIT, CFG_T_ACT, 12'd0},
    '{STEP_REG, 48'h0, 1'b0, 1'b0, 12'd0, OUT_READ_HIT, CFG_T_CAS, 12'd0},
    '{STEP_REG, 48'h0, 1'b0, 1'b0, 12'd0, OUT_READ_HIT, CFG_T_PRE, 12'd0},
    '{STEP_REG, 48'h0, 1'b0, 1'b0, 12'd0, OUT_READ_HIT, CFG_T_BUS, 12'd0},
    '{STEP_REG, 48'h0, 1'b0, 1'b0, 12'd0, OUT_READ_HIT, CFG_LINES_PER_ROW, 12'h00F},
    '{STEP_REG, 48'h0, 1'b0, 1'b0, 12'd0, OUT_READ_HIT, CFG_SPARE, 12'hABC},
    '{STEP_REQ, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b1, 12'd0, OUT_READ_CONFLICT, CFG_T_ACT, 12'd0},
    '{STEP_REQ, 48'h0000_0000_0020, 1'b0, 1'b1, 12'd0, OUT_READ_CONFLICT, CFG_T_ACT, 12'd0},
    // shift 0: bank 2 kept its row through fixed mode, so this hits
    '{STEP_REG, 48'h0, 1'b0, 1'b0, 12'd0, OUT_READ_HIT, CFG_LINES_PER_ROW, 12'd0},
    '{STEP_REQ, 48'h0000_0000_0002, 1'b0, 1'b1, 12'd0, OUT_READ_HIT, CFG_T_ACT, 12'd0},
    '{STEP_REQ, 48'h0000_0000_0012, 1'b0, 1'b1, 12'd0, OUT_READ_CONFLICT, CFG_T_ACT, 12'd0}
  };

  // shift setting per random phase; phases 4 and 8 run in fixed mode
  localparam logic [SHIFT_W-1:0] SHIFT_PLAN [NUM_PHASES] = '{
    4'd4, 4'd0, 4'd10, 4'd15, 4'd1, 4'd12, 4'd6, 4'd2, 4'd11, 4'd3
  };

  logic                   clk_i;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_wen_i   = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic [LINE_ADDR_W-1:0] line_addr_i = '0;
  logic                   is_write_i  = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [LAT_W-1:0]       latency_o;
  logic [2:0]             row_outcome_o;
  logic [CNT_W-1:0]       read_count_o;
  logic [CNT_W-1:0]       write_count_o;
  logic [SUM_W-1:0]       read_latency_total_o;
  logic [SUM_W-1:0]       write_latency_total_o;

  // local copy of the core's registers, bank table and counters
  logic               cfg_mode  = RST_ROW_BUFFER_MODE;
  logic [SHIFT_W-1:0] cfg_shift = RST_LINES_PER_ROW;
  logic [LAT_W-1:0]   cfg_fixed = RST_FIXED_LATENCY;
  logic [TIM_W-1:0]   cfg_t_act = RST_T_ACT;
  logic [TIM_W-1:0]   cfg_t_cas = RST_T_CAS;
  logic [TIM_W-1:0]   cfg_t_pre = RST_T_PRE;
  logic [TIM_W-1:0]   cfg_t_bus = RST_T_BUS;
  logic [BankCountDef-1:0] row_open = '0;
  logic [LINE_ADDR_W-1:0]  open_row [BankCountDef];
  logic [CNT_W-1:0]   reads_so_far  = '0;
  logic [CNT_W-1:0]   writes_so_far = '0;
  logic [SUM_W-1:0]   read_lat_sum  = '0;
  logic [SUM_W-1:0]   write_lat_sum = '0;

  access_result_t         due_results [$];
  logic [LINE_ADDR_W-1:0] recent_addrs [$];
  int unsigned            mismatches  = 0;
  logic                   quiet_phase = 1'b0;  // no gaps, no stalls
  logic [5:0]             hold_left   = '0;

  dram_row_buffer_latency_core DUT (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_wen_i             (cfg_wen_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .line_addr_i           (line_addr_i),
    .is_write_i            (is_write_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .latency_o             (latency_o),
    .row_outcome_o         (row_outcome_o),
    .read_count_o          (read_count_o),
    .write_count_o         (write_count_o),
    .read_latency_total_o  (read_latency_total_o),
    .write_latency_total_o (write_latency_total_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Charge one access against the local bank table and counters and return
  // everything the core should report for it.
  function automatic access_result_t charge_access(input logic [LINE_ADDR_W-1:0] addr,
                                                   input logic wr);
    logic [63:0]      row_idx;
    logic [63:0]      row;
    int unsigned      bank;
    logic [LAT_W-1:0] hit_lat;
    logic [LAT_W-1:0] full_lat;
    access_result_t   res;
    row_idx  = (64'(addr) & ADDR_MASK) >> cfg_shift;
    bank     = int'(row_idx % BankCountDef);
    row      = row_idx / BankCountDef;
    hit_lat  = LAT_W'(cfg_t_bus) + LAT_W'(cfg_t_cas);
    full_lat = hit_lat + LAT_W'(cfg_t_act) + LAT_W'(cfg_t_pre);
    if (!cfg_mode) begin
      // fixed mode leaves the table alone
      res.lat     = cfg_fixed;
      res.outcome = OUT_FIXED;
    end else if (wr) begin
      // row id is recorded, open flag untouched
      res.lat        = full_lat;
      res.outcome    = OUT_WRITE;
      open_row[bank] = row[LINE_ADDR_W-1:0];
    end else if (row_open[bank] && open_row[bank] == row[LINE_ADDR_W-1:0]) begin
      res.lat     = hit_lat;
      res.outcome = OUT_READ_HIT;
    end else if (row_open[bank]) begin
      res.lat        = full_lat;
      res.outcome    = OUT_READ_CONFLICT;
      open_row[bank] = row[LINE_ADDR_W-1:0];
    end else begin
      res.lat        = hit_lat + LAT_W'(cfg_t_act);
      res.outcome    = OUT_READ_CLOSED;
      row_open[bank] = 1'b1;
      open_row[bank] = row[LINE_ADDR_W-1:0];
    end
    if (wr) begin
      writes_so_far = writes_so_far + 1'b1;
      write_lat_sum = write_lat_sum + SUM_W'(res.lat);
    end else begin
      reads_so_far = reads_so_far + 1'b1;
      read_lat_sum = read_lat_sum + SUM_W'(res.lat);
    end
    res.reads  = reads_so_far;
    res.writes = writes_so_far;
    res.rd_sum = read_lat_sum;
    res.wr_sum = write_lat_sum;
    return res;
  endfunction

  // Present one request after a random gap and hold it until accepted.
  // Valid is left high so that a back-to-back request keeps it up.
  task automatic issue_request(input logic [LINE_ADDR_W-1:0] addr, input logic wr,
                               input logic known, input logic [LAT_W-1:0] lat,
                               input row_outcome_e outcome);
    int unsigned    pick;
    int unsigned    gap;
    access_result_t res;
    pick = $urandom_range(0, 99);
    if (quiet_phase || pick < 60) begin
      gap = 0;
    end else if (pick < 90) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(5, 30);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    line_addr_i <= addr;
    is_write_i  <= wr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // accepted at this edge
    res = charge_access(addr, wr);
    if (known) begin
      res.lat     = lat;
      res.outcome = outcome;
    end
    due_results.push_back(res);
  endtask

  // Drop valid and let the pipe run dry.
  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Single register write; wen is left high for the caller to lower.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_wen_i   <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_ROW_BUFFER_MODE: cfg_mode  = data[0];
      CFG_LINES_PER_ROW:   cfg_shift = data[SHIFT_W-1:0];
      CFG_FIXED_LATENCY:   cfg_fixed = data[LAT_W-1:0];
      CFG_T_ACT:           cfg_t_act = data[TIM_W-1:0];
      CFG_T_CAS:           cfg_t_cas = data[TIM_W-1:0];
      CFG_T_PRE:           cfg_t_pre = data[TIM_W-1:0];
      CFG_T_BUS:           cfg_t_bus = data[TIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Output stall: mostly short bursts, now and then a long one.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1'b1;
    end else if (quiet_phase || $urandom_range(0, 99) < 70) begin
      out_stall_i <= 1'b0;
      hold_left   <= quiet_phase ? 6'd0 : 6'($urandom_range(0, 4));
    end else begin
      out_stall_i <= 1'b1;
      hold_left   <= ($urandom_range(0, 9) == 0) ? 6'($urandom_range(5, 30))
                                                  : 6'($urandom_range(0, 2));
    end
  end

  // Result side: values sampled are the ones that stood before this edge.
  always @(posedge clk_i) begin : watch_results
    access_result_t head;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        $display("%0t: result with no request pending: expected none got latency %0d",
                 $time, latency_o);
        mismatches++;
      end else begin
        head = due_results.pop_front();
        check_field("latency", 64'(head.lat), 64'(latency_o));
        check_field("row_outcome", 64'(head.outcome), 64'(row_outcome_o));
        check_field("read_count", 64'(head.reads), 64'(read_count_o));
        check_field("write_count", 64'(head.writes), 64'(write_count_o));
        check_field("read_latency_total", head.rd_sum, read_latency_total_o);
        check_field("write_latency_total", head.wr_sum, write_latency_total_o);
      end
    end
  end

  initial begin
    logic                   cfg_open;
    logic [LINE_ADDR_W-1:0] addr;
    logic [63:0]            wide;
    logic [31:0]            junk;
    logic                   mode;
    int unsigned            pick;
    cfg_open = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // prime a row id into every bank; writes keep the banks closed
    for (int b = 0; b < BankCountDef; b++) begin
      wide = {$urandom(), $urandom()};
      issue_request({wide[LINE_ADDR_W-1:8], 4'(b), 4'h0}, 1'b1, 1'b0, '0, OUT_WRITE);
    end

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (SCRIPT[i].kind == STEP_REG) begin
        if (!cfg_open) drain_requests();
        cfg_open = 1'b1;
        write_reg(SCRIPT[i].reg_idx, SCRIPT[i].reg_data);
      end else begin
        if (cfg_open) cfg_wen_i <= 1'b0;
        cfg_open = 1'b0;
        issue_request(SCRIPT[i].addr, SCRIPT[i].wr, SCRIPT[i].known, SCRIPT[i].lat,
                      SCRIPT[i].outcome);
      end
    end

    // Random phases. Most requests revisit a recent line (same row or same bank,
    // other row) so hits and conflicts are common; the rest are fully random.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_requests();
      quiet_phase = (ph % 4 == 1);
      mode = !(ph == 4 || ph == 8);
      junk = $urandom();
      write_reg(CFG_ROW_BUFFER_MODE, {junk[10:0], mode});
      write_reg(CFG_LINES_PER_ROW, {junk[7:0], SHIFT_PLAN[ph]});
      write_reg(CFG_FIXED_LATENCY, 12'($urandom()));
      for (int t = 0; t < 4; t++) begin
        junk = $urandom();
        if (ph == 2) begin
          junk[TIM_W-1:0] = '1;
        end else if (ph == 5) begin
          junk[TIM_W-1:0] = '0;
        end
        write_reg(cfg_idx_e'(CFG_T_ACT + t), junk[CFG_DATA_W-1:0]);
      end
      cfg_wen_i <= 1'b0;

      for (int n = 0; n < PHASE_REQS; n++) begin
        pick = $urandom_range(0, 99);
        wide = {$urandom(), $urandom()};
        if (pick < 20 || recent_addrs.size() == 0) begin
          addr = wide[LINE_ADDR_W-1:0];
        end else begin
          addr = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
          if (pick < 70) begin
            addr = addr ^ (wide[LINE_ADDR_W-1:0] & ((48'd1 << cfg_shift) - 48'd1));
          end else begin
            addr = addr ^ (wide[LINE_ADDR_W-1:0] << (cfg_shift + BANK_SHIFT));
          end
        end
        recent_addrs.push_back(addr);
        if (recent_addrs.size() > RECENT_DEPTH) void'(recent_addrs.pop_front());
        issue_request(addr, ($urandom_range(0, 3) == 0), 1'b0, '0, OUT_READ_HIT);
      end
    end

    drain_requests();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(RUN_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire

/* dram_row_buffer_latency_core.f */
hdl/drbl_pkg.sv
hdl/drbl_bank_map.sv
hdl/dram_row_buffer_latency_core.sv
bench/tb_dram_row_buffer_latency_core.sv
